### rtl/premultiplied_srgb_to_linear_texel_assert.svh
// Assertion macros used by the checker file.
`ifndef PREMULTIPLIED_SRGB_TO_LINEAR_TEXEL_ASSERT_SVH
`define PREMULTIPLIED_SRGB_TO_LINEAR_TEXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PSTL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pstl check failed");

// Consequent checked a fixed number of cycles after the antecedent.
`define PSTL_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("pstl latency check failed");

`endif

### rtl/pstl_pkg.sv
`default_nettype none

package pstl_pkg;

   localparam int unsigned PSTL_LUT_FRACTION_BITS = 16;
   localparam int unsigned PSTL_LUT_DEPTH         = 256;
   localparam int unsigned PSTL_NUM_W             = 17;  // 510*c + a
   localparam int unsigned PSTL_DEN_W             = 9;   // 2*a
   localparam int unsigned PSTL_STAGES            = 5;   // request to response

   localparam logic [63:0] Q31_ONE = 64'd1 << 31;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } pstl_req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
   } pstl_rsp_type;

   function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> 31;
   endfunction

   function automatic logic [63:0] q31_pow5(input logic [63:0] r);
      logic [63:0] r2;
      logic [63:0] r4;
      r2 = q31_mul(r, r);
      r4 = q31_mul(r2, r2);
      return q31_mul(r4, r);
   endfunction

   // sRGB-to-linear table entry, evaluated at elaboration only.
   // Linear segment for u <= 10, else x^2 * (x^2)^(1/5) in Q31.
   function automatic logic [63:0] srgb_lut_entry(input int unsigned u,
                                                   input int unsigned frac_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] root;
      logic [63:0] trial;
      logic [63:0] prod;
      if (u <= 10) begin
         return (((64'(u) * 64'd10) << frac_bits) + 64'd16473) / 64'd32946;
      end
      x = (((64'(u) * 64'd1000 + 64'd14025) << 31) + 64'd134512) / 64'd269025;
      if (x > Q31_ONE) begin
         x = Q31_ONE;
      end
      x2 = (x * x + (Q31_ONE >> 1)) >> 31;
      // largest root with root^5 <= x2; greedy bit search
      root = 64'd0;
      if (q31_pow5(Q31_ONE) <= x2) begin
         root = Q31_ONE;
      end else begin
         for (int b = 30; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (q31_pow5(trial) <= x2) begin
               root = trial;
            end
         end
      end
      prod = x2 * root;
      return (prod + (64'd1 << (61 - frac_bits))) >> (62 - frac_bits);
   endfunction

endpackage

`default_nettype wire

### rtl/premultiplied_srgb_to_linear_texel.sv
`default_nettype none

// Channel    Ports                          Direction  Handshake
// request    start, busy, req_data          in         start && !busy
// response   rsp_strobe, rsp_data           out        rsp_strobe, one cycle
//
// One request per cycle, sustained outside reset. The pipeline holds three
// stages of restoring division (unpremultiply), one stage for the linear
// table read, and one for the alpha remultiply and rounding.
// Reset is synchronous, active high; it clears the valid pipe and holds
// busy high while asserted. The receiver cannot stall, so no request is
// ever held back once reset is released.
module premultiplied_srgb_to_linear_texel #(
   parameter int unsigned LUT_FRACTION_BITS = pstl_pkg::PSTL_LUT_FRACTION_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pstl_pkg::pstl_req_type req_data,
   output logic                  rsp_strobe,
   output pstl_pkg::pstl_rsp_type rsp_data
);
   import pstl_pkg::*;

   logic                   accept;
   logic [PSTL_STAGES-1:0] valid_in, valid_ff;
   logic [7:0]             alpha_ff [PSTL_STAGES];   // alpha travels with the request
   logic [7:0]             straight [3];
   logic [7:0]             lin      [3];
   logic [7:0]             color    [3];

   assign busy   = reset;
   assign accept = start && !busy;

   assign color[0] = req_data.red_in;
   assign color[1] = req_data.green_in;
   assign color[2] = req_data.blue_in;

   // Per-channel lanes: divider then lookup/remultiply.
   // Alpha 0 needs no special path: remultiply by 0 yields 0.
   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      pstl_unpremul u_unpremul (
         .clock    (clock),
         .color    (color[ch]),
         .alpha    (req_data.alpha_in),
         .straight (straight[ch])
      );

      pstl_relin #(
         .LUT_FRACTION_BITS (LUT_FRACTION_BITS)
      ) u_relin (
         .clock    (clock),
         .straight (straight[ch]),
         .alpha    (alpha_ff[PSTL_STAGES-2]),
         .result   (lin[ch])
      );
   end

   always_comb begin
      valid_in = {valid_ff[PSTL_STAGES-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload shift, no reset
   always_ff @(posedge clock) begin
      alpha_ff[0] <= req_data.alpha_in;
      for (int i = 1; i < PSTL_STAGES; i++) begin
         alpha_ff[i] <= alpha_ff[i-1];
      end
   end

   always_comb begin
      rsp_strobe         = valid_ff[PSTL_STAGES-1];
      rsp_data.red_out   = lin[0];
      rsp_data.green_out = lin[1];
      rsp_data.blue_out  = lin[2];
      rsp_data.alpha_out = alpha_ff[PSTL_STAGES-1];
   end

endmodule

`default_nettype wire

### rtl/pstl_unpremul.sv
`default_nettype none

// Unpremultiply one channel: floor((510c + a) / 2a), saturated at 255.
// Restoring divider, three register stages (3 + 3 + 2 quotient bits).
module pstl_unpremul (
   input  logic       clock,
   input  logic [7:0] color,
   input  logic [7:0] alpha,
   output logic [7:0] straight
);
   import pstl_pkg::*;

   typedef struct packed {
      logic [PSTL_NUM_W-1:0] rem;
      logic [7:0]            quo;
      logic                  sat;
      logic [PSTL_DEN_W-1:0] den;
   } div_state_type;

   div_state_type s1_in, s1_ff;
   div_state_type s2_in, s2_ff;
   div_state_type s3_in;
   logic [PSTL_NUM_W-1:0] num;
   logic [7:0]            straight_in, straight_ff;

   function automatic div_state_type div_step(input div_state_type s, input int k);
      div_state_type         r;
      logic [PSTL_NUM_W-1:0] sub;
      r   = s;
      sub = PSTL_NUM_W'(s.den) << k;
      if (s.rem >= sub) begin
         r.rem = s.rem - sub;
         r.quo = {s.quo[6:0], 1'b1};
      end else begin
         r.quo = {s.quo[6:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      num       = PSTL_NUM_W'(color) * PSTL_NUM_W'(510) + PSTL_NUM_W'(alpha);
      s1_in.den = {alpha, 1'b0};
      s1_in.sat = num >= {s1_in.den, 8'd0};  // quotient would exceed 255
      s1_in.rem = num;
      s1_in.quo = '0;
      for (int k = 7; k >= 5; k--) begin
         s1_in = div_step(s1_in, k);
      end
   end

   always_comb begin
      s2_in = s1_ff;
      for (int k = 4; k >= 2; k--) begin
         s2_in = div_step(s2_in, k);
      end
   end

   always_comb begin
      s3_in = s2_ff;
      for (int k = 1; k >= 0; k--) begin
         s3_in = div_step(s3_in, k);
      end
      straight_in = s3_in.sat ? 8'hFF : s3_in.quo;
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      straight_ff <= straight_in;
   end

   assign straight = straight_ff;

endmodule

`default_nettype wire

### rtl/pstl_relin.sv
`default_nettype none

// Table lookup of the linear value, then remultiply by alpha with rounding.
module pstl_relin #(
   parameter int unsigned LUT_FRACTION_BITS = pstl_pkg::PSTL_LUT_FRACTION_BITS
) (
   input  logic       clock,
   input  logic [7:0] straight,
   input  logic [7:0] alpha,      // alpha aligned with the lookup register
   output logic [7:0] result
);
   import pstl_pkg::*;

   localparam int unsigned LUT_W  = LUT_FRACTION_BITS + 1;  // holds 1.0
   localparam int unsigned PROD_W = LUT_W + 8;

   logic [LUT_W-1:0]  lut_rom [PSTL_LUT_DEPTH];
   logic [LUT_W-1:0]  lut_in, lut_ff;
   logic [PROD_W-1:0] prod;
   logic [7:0]        result_in, result_ff;

   for (genvar i = 0; i < PSTL_LUT_DEPTH; i++) begin : g_lut
      assign lut_rom[i] = LUT_W'(srgb_lut_entry(i, LUT_FRACTION_BITS));
   end

   always_comb begin
      lut_in    = lut_rom[straight];
      prod      = PROD_W'(lut_ff) * PROD_W'(alpha)
                + (PROD_W'(1) << (LUT_FRACTION_BITS - 1));
      result_in = prod[LUT_FRACTION_BITS +: 8];
   end

   always_ff @(posedge clock) begin
      lut_ff    <= lut_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

### rtl/pstl_checker.sv
`default_nettype none

`include "premultiplied_srgb_to_linear_texel_assert.svh"

module pstl_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input pstl_pkg::pstl_req_type req_data,
   input logic                   rsp_strobe,
   input pstl_pkg::pstl_rsp_type rsp_data
);
   import pstl_pkg::*;

   // every request gives a response a fixed latency later
   `PSTL_ASSERT_DELAY(a_latency, clock, reset, start && !busy, PSTL_STAGES, rsp_strobe)

   // no response without a matching request
   `PSTL_ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_strobe, $past(start && !busy, PSTL_STAGES))

   // alpha rides through untouched
   `PSTL_ASSERT_IMPLY(a_alpha_pass, clock, reset, rsp_strobe, rsp_data.alpha_out == $past(req_data.alpha_in, PSTL_STAGES))

   // premultiplied output never exceeds its alpha
   `PSTL_ASSERT_IMPLY(a_color_bound, clock, reset, rsp_strobe, (rsp_data.red_out <= rsp_data.alpha_out) && (rsp_data.green_out <= rsp_data.alpha_out) && (rsp_data.blue_out <= rsp_data.alpha_out))

endmodule

bind premultiplied_srgb_to_linear_texel pstl_checker u_pstl_checker (.*);

`default_nettype wire
